>>> hdl/cle_pkg.sv
package cle_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths of the request and result items
  localparam int REQ_W  = 4;
  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int FPOS_W = 6;
  localparam int CNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 4'd0,
    REQ_INS_LAST  = 4'd1,
    REQ_INS_AT    = 4'd2,
    REQ_DEL_FRONT = 4'd3,
    REQ_DEL_LAST  = 4'd4,
    REQ_DEL_AT    = 4'd5,
    REQ_SEARCH    = 4'd6,
    REQ_COUNT     = 4'd7,
    REQ_CLEAR     = 4'd8
  } cle_req_t;

  typedef enum logic [1:0] {
    OP_INS,
    OP_DEL,
    OP_SEARCH,
    OP_OTHER
  } cle_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ALLOC,
    ST_WALK,
    ST_INS_WR,
    ST_INS_LINK,
    ST_DEL_RD,
    ST_SEARCH,
    ST_FINISH
  } cle_state_t;

  // Controller to datapath: one strobe per phase
  typedef struct packed {
    logic accept;
    logic dispatch;
    logic alloc;
    logic walk;
    logic ins_wr;
    logic ins_link;
    logic del_rd;
    logic search;
    logic finish;
  } cle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cle_op_t op;
    logic    legal;
    logic    free_hit;
    logic    walk_end;
    logic    search_end;
    logic    out_free;
  } cle_stat_t;

endpackage

>>> hdl/cle_in_if.sv
interface cle_in_if;
  import cle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] value_in;
  logic [POS_W-1:0]         position;

  modport source (output valid, req_type, value_in, position, input ready);
  modport sink   (input valid, req_type, value_in, position, output ready);
endinterface

>>> hdl/cle_out_if.sv
interface cle_out_if;
  import cle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] value_out;
  logic                     found;
  logic [FPOS_W-1:0]        found_pos;
  logic [CNT_W-1:0]         node_count;

  modport source (output valid, ok, value_out, found, found_pos, node_count, input ready);
  modport sink   (input valid, ok, value_out, found, found_pos, node_count, output ready);
endinterface

>>> hdl/circular_list_engine_unit.sv
// Sequence per item: count, clear and refused requests finish after dispatch; a search
//   compares nodes until a hit or the last node; a delete walks to the position and reads
//   the node; an insert probes for the lowest free slot, walks (middle only), writes and links.
// Throughput: one item at a time; the next item is taken the cycle after the result is
//   loaded into the output register, which holds it while the receiver stalls.
// Reset: synchronous, active low; empties the list and the allocation map.
module circular_list_engine_unit #(
  parameter int CAPACITY   = cle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = cle_pkg::VALUE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  cle_in_if.sink   in_ch,
  cle_out_if.source out_ch
);
  import cle_pkg::*;

  cle_cmd_t  cmd;
  cle_stat_t stat;

  // Sequencer: decides which phase runs each cycle
  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Node store, list registers and the result register
  cle_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (in_ch.req_type),
    .value_in   (in_ch.value_in),
    .position   (in_ch.position),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .ok         (out_ch.ok),
    .value_out  (out_ch.value_out),
    .found      (out_ch.found),
    .found_pos  (out_ch.found_pos),
    .node_count (out_ch.node_count)
  );
endmodule

>>> hdl/cle_ram.sv
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/cle_ctrl.sv
module cle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cle_pkg::cle_stat_t   stat,
  output cle_pkg::cle_cmd_t    cmd
);
  import cle_pkg::*;

  cle_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!stat.legal) begin
          state_nxt = ST_FINISH;
        end else begin
          unique case (stat.op)
            OP_INS:    state_nxt = ST_ALLOC;
            OP_DEL:    state_nxt = ST_WALK;
            OP_SEARCH: state_nxt = ST_SEARCH;
            default:   state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_ALLOC: begin
        if (stat.free_hit) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (stat.walk_end) state_nxt = (stat.op == OP_INS) ? ST_INS_WR : ST_DEL_RD;
      end
      ST_INS_WR:   state_nxt = ST_INS_LINK;
      ST_INS_LINK: state_nxt = ST_FINISH;
      ST_DEL_RD:   state_nxt = ST_FINISH;
      ST_SEARCH: begin
        if (stat.search_end) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DISPATCH: cmd.dispatch = 1'b1;
      ST_ALLOC:    cmd.alloc    = 1'b1;
      ST_WALK:     cmd.walk     = 1'b1;
      ST_INS_WR:   cmd.ins_wr   = 1'b1;
      ST_INS_LINK: cmd.ins_link = 1'b1;
      ST_DEL_RD:   cmd.del_rd   = 1'b1;
      ST_SEARCH:   cmd.search   = 1'b1;
      ST_FINISH:   cmd.finish   = stat.out_free;
      default: ;
    endcase
  end
endmodule

>>> hdl/cle_dp.sv
module cle_dp #(
  parameter int CAPACITY   = cle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = cle_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cle_pkg::cle_cmd_t                cmd,
  output cle_pkg::cle_stat_t               stat,
  input  logic [cle_pkg::REQ_W-1:0]        req_type,
  input  logic signed [cle_pkg::DATA_W-1:0] value_in,
  input  logic [cle_pkg::POS_W-1:0]        position,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             ok,
  output logic signed [cle_pkg::DATA_W-1:0] value_out,
  output logic                             found,
  output logic [cle_pkg::FPOS_W-1:0]       found_pos,
  output logic [cle_pkg::CNT_W-1:0]        node_count
);
  import cle_pkg::*;

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [REQ_W-1:0]      req_r, req_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]         size_r, size_nxt;
  logic [SW-1:0]         tail_r, tail_nxt;
  logic [CAPACITY-1:0]   used_r, used_nxt;
  logic [SW-1:0]         scan_r, scan_nxt;
  logic [SW-1:0]         cur_r, cur_nxt;
  logic [SW-1:0]         pred_r, pred_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [DATA_W-1:0]     res_vout_r, res_vout_nxt;
  logic [CW-1:0]         res_fpos_r, res_fpos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  ok_r, ok_nxt;
  logic [DATA_W-1:0]     vout_r, vout_nxt;
  logic                  found_r, found_nxt;
  logic [FPOS_W-1:0]     fpos_r, fpos_nxt;
  logic [CNT_W-1:0]      ncount_r, ncount_nxt;

  // Node store
  logic [SW-1:0]         nrd, raddr, nx_waddr, nx_wdata;
  logic                  nx_we;
  logic [VALUE_BITS-1:0] vrd;

  logic [31:0] size32, pos32;
  logic        empty, full, ins_legal, del_legal, at_back, ins_mid, hit, last;
  logic [CW-1:0] ins_len, del_len, hit_pos;
  cle_op_t     op;

  always_comb begin
    case (req_r) inside
      REQ_INS_FRONT, REQ_INS_LAST, REQ_INS_AT: op = OP_INS;
      REQ_DEL_FRONT, REQ_DEL_LAST, REQ_DEL_AT: op = OP_DEL;
      REQ_SEARCH:                              op = OP_SEARCH;
      default:                                 op = OP_OTHER;
    endcase
  end

  assign size32    = 32'(size_r);
  assign pos32     = 32'(pos_r);
  assign empty     = (size_r == '0);
  assign full      = (size32 >= 32'(CAPACITY));
  assign ins_legal = !full && ((req_r != REQ_INS_AT) || (pos32 <= size32));
  assign del_legal = !empty && ((req_r != REQ_DEL_AT) || (pos32 < size32));
  assign at_back   = (req_r == REQ_INS_LAST) || ((req_r == REQ_INS_AT) && (pos32 == size32));
  assign ins_mid   = (req_r == REQ_INS_AT) && (pos_r != '0) && (pos32 != size32);
  assign ins_len   = ins_mid ? CW'(pos_r) : '0;

  always_comb begin
    case (req_r)
      REQ_DEL_LAST: del_len = size_r - CW'(1);
      REQ_DEL_AT:   del_len = CW'(pos_r);
      default:      del_len = '0;
    endcase
  end

  // Tail node is compared first, then the front onward
  assign hit     = (vrd == key_r);
  assign last    = (32'(cnt_r) == size32 - 32'd1);
  assign hit_pos = (cnt_r == '0) ? (size_r - CW'(1)) : (cnt_r - CW'(1));

  assign raddr    = (cmd.walk || cmd.search) ? nrd : tail_r;
  assign nx_we    = cmd.ins_wr || (cmd.ins_link && !empty) ||
                    (cmd.del_rd && (size_r != CW'(1)));
  assign nx_waddr = cmd.ins_wr ? scan_r : pred_r;
  assign nx_wdata = cmd.ins_wr   ? (empty ? scan_r : cur_r) :
                    cmd.ins_link ? scan_r : nrd;

  cle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (raddr),
    .rdata (nrd)
  );

  cle_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (cmd.ins_wr),
    .waddr (scan_r),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (vrd)
  );

  always_comb begin
    req_nxt       = req_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    size_nxt      = size_r;
    tail_nxt      = tail_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    cur_nxt       = cur_r;
    pred_nxt      = pred_r;
    cnt_nxt       = cnt_r;
    res_ok_nxt    = res_ok_r;
    res_found_nxt = res_found_r;
    res_vout_nxt  = res_vout_r;
    res_fpos_nxt  = res_fpos_r;
    ok_nxt        = ok_r;
    vout_nxt      = vout_r;
    found_nxt     = found_r;
    fpos_nxt      = fpos_r;
    ncount_nxt    = ncount_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.accept) begin
      req_nxt = req_type;
      key_nxt = VALUE_BITS'(value_in);
      pos_nxt = position;
    end

    if (cmd.dispatch) begin
      cur_nxt       = tail_r;
      scan_nxt      = '0;
      cnt_nxt       = (op == OP_INS) ? ins_len : (op == OP_DEL) ? del_len : '0;
      res_ok_nxt    = (op == OP_SEARCH) || (req_r == REQ_COUNT) || (req_r == REQ_CLEAR);
      res_found_nxt = 1'b0;
      res_vout_nxt  = '0;
      res_fpos_nxt  = '0;
      if (req_r == REQ_CLEAR) begin
        used_nxt = '0;
        tail_nxt = '0;
        size_nxt = '0;
      end
    end

    // Lowest free slot, one slot a cycle
    if (cmd.alloc && used_r[scan_r]) begin
      scan_nxt = scan_r + SW'(1);
    end

    // Advance one link a cycle; at the end keep predecessor and successor
    if (cmd.walk) begin
      cur_nxt = nrd;
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - CW'(1);
      end else begin
        pred_nxt = cur_r;
      end
    end

    if (cmd.ins_link) begin
      used_nxt[scan_r] = 1'b1;
      size_nxt         = size_r + CW'(1);
      res_ok_nxt       = 1'b1;
      if (empty || at_back) tail_nxt = scan_r;
    end

    if (cmd.del_rd) begin
      used_nxt[cur_r] = 1'b0;
      size_nxt        = size_r - CW'(1);
      res_ok_nxt      = 1'b1;
      res_vout_nxt    = 32'(vrd);
      if (size_r == CW'(1)) begin
        tail_nxt = '0;
      end else if (cur_r == tail_r) begin
        tail_nxt = pred_r;
      end
    end

    if (cmd.search) begin
      if (hit) begin
        res_found_nxt = 1'b1;
        res_fpos_nxt  = hit_pos;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = res_ok_r;
      vout_nxt      = res_vout_r;
      found_nxt     = res_found_r;
      fpos_nxt      = FPOS_W'(res_fpos_r);
      ncount_nxt    = CNT_W'(size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      tail_r      <= tail_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r       <= req_nxt;
    key_r       <= key_nxt;
    pos_r       <= pos_nxt;
    scan_r      <= scan_nxt;
    cur_r       <= cur_nxt;
    pred_r      <= pred_nxt;
    cnt_r       <= cnt_nxt;
    res_ok_r    <= res_ok_nxt;
    res_found_r <= res_found_nxt;
    res_vout_r  <= res_vout_nxt;
    res_fpos_r  <= res_fpos_nxt;
    ok_r        <= ok_nxt;
    vout_r      <= vout_nxt;
    found_r     <= found_nxt;
    fpos_r      <= fpos_nxt;
    ncount_r    <= ncount_nxt;
  end

  always_comb begin
    stat.op         = op;
    stat.free_hit   = !used_r[scan_r];
    stat.walk_end   = (cnt_r == '0);
    stat.search_end = hit || last;
    stat.out_free   = !out_valid_r || out_ready;
    case (op)
      OP_INS:    stat.legal = ins_legal;
      OP_DEL:    stat.legal = del_legal;
      OP_SEARCH: stat.legal = !empty;
      default:   stat.legal = 1'b1;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign ok         = ok_r;
  assign value_out  = vout_r;
  assign found      = found_r;
  assign found_pos  = fpos_r;
  assign node_count = ncount_r;

  a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r == '0) |-> (tail_r == '0))
    else $error("empty list with nonzero tail");

  a_map_size: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(size_r))
    else $error("allocation map disagrees with node count");

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_link |-> !used_r[scan_r])
    else $error("insert into an occupied slot");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del_rd |=> (size_r == $past(size_r) - CW'(1)))
    else $error("delete did not shrink the list by one");
endmodule

>>> sim/cle_checker.sv
`timescale 1ns / 100ps

module cle_checker (
  input  logic        clk,
  input  logic        rst_n,
  cle_in_if           in_mon,
  cle_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned list_len,
  output int unsigned results_seen,
  output int unsigned refused_seen
);
  import cle_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] value_out;
    logic              found;
    logic [FPOS_W-1:0] found_pos;
    logic [CNT_W-1:0]  node_count;
  } list_resp_t;

  logic [DATA_W-1:0] lst_val [CAP];
  logic [5:0]        lst_nxt [CAP];
  logic [CAP-1:0]    lst_used;
  logic [5:0]        lst_tail;
  int unsigned       lst_size;

  list_resp_t resp_q[$];

  function automatic logic [5:0] hop(logic [5:0] s, int unsigned steps);
    logic [5:0] r;
    r = s;
    for (int i = 0; i < steps && i < CAP; i++) r = lst_nxt[r];
    return r;
  endfunction

  // Link a new node after pred (or after the tail), lowest free slot first.
  function automatic void link_node(logic [DATA_W-1:0] v, bit to_back, logic [5:0] pred,
                                    bit by_pred);
    logic [5:0] n;
    logic [5:0] p;
    n = '0;
    for (int s = CAP - 1; s >= 0; s--) if (!lst_used[s]) n = s[5:0];
    lst_used[n] = 1'b1;
    lst_val[n]  = v;
    if (lst_size == 0) begin
      lst_nxt[n] = n;
      lst_tail   = n;
    end else begin
      p          = by_pred ? pred : lst_tail;
      lst_nxt[n] = lst_nxt[p];
      lst_nxt[p] = n;
      if (to_back) lst_tail = n;
    end
    lst_size++;
  endfunction

  function automatic list_resp_t apply_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] v,
                                               logic [POS_W-1:0] pos);
    list_resp_t  r;
    int unsigned n;
    int unsigned idx;
    logic [5:0]  pred;
    logic [5:0]  victim;
    logic [5:0]  s;
    bit          full;
    r    = '0;
    n    = lst_size;
    full = (n >= CAP);
    case (req)
      REQ_INS_FRONT: if (!full) begin link_node(v, 0, '0, 0); r.ok = 1; end
      REQ_INS_LAST:  if (!full) begin link_node(v, 1, '0, 0); r.ok = 1; end
      REQ_INS_AT: begin
        if (!full && pos <= n) begin
          if (pos == 0)      link_node(v, 0, '0, 0);
          else if (pos == n) link_node(v, 1, '0, 0);
          else               link_node(v, 0, hop(lst_tail, pos), 1);
          r.ok = 1;
        end
      end
      REQ_DEL_FRONT, REQ_DEL_LAST, REQ_DEL_AT: begin
        idx = (req == REQ_DEL_FRONT) ? 0 : (req == REQ_DEL_LAST) ? n - 1 : pos;
        if (n != 0 && idx < n) begin
          if (n == 1) begin
            r.value_out        = lst_val[lst_tail];
            lst_used[lst_tail] = 1'b0;
            lst_tail           = '0;
            lst_size           = 0;
          end else begin
            pred          = hop(lst_tail, idx);
            victim        = lst_nxt[pred];
            r.value_out   = lst_val[victim];
            lst_nxt[pred] = lst_nxt[victim];
            lst_used[victim] = 1'b0;
            if (victim == lst_tail) lst_tail = pred;
            lst_size--;
          end
          r.ok = 1;
        end
      end
      REQ_SEARCH: begin
        r.ok = 1;
        if (n > 0) begin
          // tail first, then front onward
          if (lst_val[lst_tail] == v) begin
            r.found     = 1;
            r.found_pos = FPOS_W'(n - 1);
          end else begin
            s = lst_nxt[lst_tail];
            for (int i = 0; i + 1 < n; i++) begin
              if (lst_val[s] == v) begin
                r.found     = 1;
                r.found_pos = FPOS_W'(i);
                break;
              end
              s = lst_nxt[s];
            end
          end
        end
      end
      REQ_COUNT: r.ok = 1;
      REQ_CLEAR: begin
        lst_used = '0;
        lst_tail = '0;
        lst_size = 0;
        r.ok     = 1;
      end
      default: ;
    endcase
    r.node_count = CNT_W'(lst_size);
    return r;
  endfunction

  assign list_len = lst_size;

  always @(posedge clk) begin
    list_resp_t got;
    list_resp_t want;
    if (!rst_n) begin
      lst_used     <= '0;
      lst_tail     <= '0;
      lst_size     <= 0;
      fail_count   <= 0;
      results_seen <= 0;
      refused_seen <= 0;
      pending      <= 0;
      resp_q.delete();
    end else begin
      // check the outgoing item before queueing any new prediction
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.ok, out_mon.value_out, out_mon.found, out_mon.found_pos,
                out_mon.node_count};
        results_seen <= results_seen + 1;
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = resp_q.pop_front();
          if (!want.ok) refused_seen <= refused_seen + 1;
          if (got !== want) begin
            $display("%0t: mismatch exp ok=%b val=%h fnd=%b fpos=%0d cnt=%0d",
                     $time, want.ok, want.value_out, want.found, want.found_pos,
                     want.node_count);
            $display("%0t:          act ok=%b val=%h fnd=%b fpos=%0d cnt=%0d",
                     $time, got.ok, got.value_out, got.found, got.found_pos,
                     got.node_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        resp_q.push_back(apply_request(in_mon.req_type, in_mon.value_in, in_mon.position));
      pending <= resp_q.size();
    end
  end

endmodule

>>> sim/circular_list_engine_unit_tb.sv
`timescale 1ns / 100ps

module circular_list_engine_unit_tb;
  import cle_pkg::*;

  // request codes the block has no meaning for
  localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 4'd9;
  localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 4'd15;
  localparam int RANDOM_ITEMS = 1400;

  logic clk;
  logic rst_n;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  int unsigned fail_count, pending, list_len, results_seen, refused_seen;
  int unsigned items_sent;
  bit          no_idle;      // stretch with no idling on either side
  int unsigned hold_cycles;  // long receiver hold-off
  logic [DATA_W-1:0] recent [32];

  circular_list_engine_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  cle_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .list_len    (list_len),
    .results_seen(results_seen),
    .refused_seen(refused_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random idling, a quiet stretch, and a long counted hold-off.
  initial begin
    out_ch.ready = 1'b0;
    hold_cycles  = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = no_idle || ($urandom_range(99) >= 8);
      end
    end
  end

  // Offer one item and hold it until accepted; random gaps in front.
  task automatic send_req(logic [REQ_W-1:0] req, logic [DATA_W-1:0] v, logic [POS_W-1:0] pos);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 8) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.req_type = req;
    in_ch.value_in = v;
    in_ch.position = pos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    if (req <= REQ_INS_AT) recent[items_sent % 32] = v;
    items_sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return DATA_W'($urandom_range(7));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(bit del);
    int unsigned lim;
    lim = del ? (list_len > 0 ? list_len - 1 : 0) : list_len;
    if ($urandom_range(9) == 0) return POS_W'($urandom_range(127));
    return POS_W'($urandom_range(lim));
  endfunction

  task automatic random_req();
    int unsigned k;
    logic [REQ_W-1:0] req;
    k = $urandom_range(99);
    if (k < 45)      req = REQ_W'($urandom_range(REQ_INS_AT));
    else if (k < 75) req = REQ_W'($urandom_range(REQ_DEL_AT, REQ_DEL_FRONT));
    else if (k < 92) req = REQ_SEARCH;
    else if (k < 95) req = REQ_COUNT;
    else if (k < 97) req = REQ_CLEAR;
    else             req = REQ_W'($urandom_range(REQ_UNDEF_HI, REQ_UNDEF_LO));
    if (req == REQ_SEARCH && $urandom_range(2) != 0)
      send_req(req, recent[$urandom_range(31)], POS_W'($urandom_range(127)));
    else
      send_req(req, pick_value(), pick_pos(req >= REQ_DEL_FRONT));
  endtask

  task automatic random_req_fill();
    send_req(REQ_W'($urandom_range(REQ_INS_AT)), pick_value(), pick_pos(0));
  endtask

  initial begin
    int unsigned scen;
    rst_n          = 1'b0;
    no_idle        = 1'b0;
    items_sent     = 0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_COUNT;
    in_ch.value_in = '0;
    in_ch.position = '0;
    foreach (recent[i]) recent[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list, extremes, bad positions, duplicates, clear.
    send_req(REQ_COUNT, '0, '0);
    send_req(REQ_DEL_FRONT, '0, '0);
    send_req(REQ_DEL_LAST, '0, '0);
    send_req(REQ_DEL_AT, '0, '0);
    send_req(REQ_SEARCH, 32'h8000_0000, '0);
    send_req(REQ_INS_AT, 32'd5, 7'd1);
    send_req(REQ_INS_FRONT, 32'h8000_0000, '0);
    send_req(REQ_INS_LAST, 32'h7FFF_FFFF, '0);
    send_req(REQ_INS_AT, 32'hFFFF_FFFF, 7'd1);
    send_req(REQ_INS_AT, 32'd0, 7'd3);
    send_req(REQ_INS_AT, 32'd7, 7'd0);
    send_req(REQ_INS_AT, 32'd9, 7'd127);
    send_req(REQ_INS_LAST, 32'd7, '0);
    send_req(REQ_SEARCH, 32'd7, '0);
    send_req(REQ_SEARCH, 32'hFFFF_FFFF, '0);
    send_req(REQ_SEARCH, 32'd12345, '0);
    send_req(REQ_DEL_AT, '0, 7'd6);
    send_req(REQ_DEL_AT, '0, 7'd2);
    send_req(REQ_DEL_LAST, '0, '0);
    send_req(REQ_DEL_FRONT, '0, '0);
    send_req(REQ_UNDEF_LO, 32'hFFFF_FFFF, 7'h7F);
    send_req(REQ_UNDEF_HI, '0, '0);
    send_req(REQ_CLEAR, '0, '0);
    send_req(REQ_INS_FRONT, 32'd1, '0);
    send_req(REQ_DEL_AT, '0, 7'd0);

    // Hold the receiver off while items keep coming, drain, then run without gaps.
    hold_cycles = 300;
    repeat (6) random_req();
    wait (pending == 0);
    no_idle = 1'b1;
    repeat (60) random_req();
    no_idle = 1'b0;

    // Random: mostly mixed traffic, with fill-to-full and drain-to-empty runs.
    while (items_sent < RANDOM_ITEMS) begin
      scen = $urandom_range(19);
      if (scen == 0 && items_sent > 300) begin
        while (list_len < CAPACITY_DEF) random_req_fill();
        repeat (3) send_req(REQ_W'($urandom_range(REQ_INS_AT)), pick_value(),
                            POS_W'($urandom_range(64)));
      end else if (scen == 1) begin
        while (list_len > 0) send_req(REQ_W'($urandom_range(REQ_DEL_AT, REQ_DEL_FRONT)),
                                      '0, pick_pos(1));
        send_req(REQ_DEL_LAST, '0, '0);
      end else if (scen == 2) begin
        // hold the receiver off while items keep coming
        hold_cycles = 400;
        repeat (4) random_req();
      end else if (scen == 3) begin
        // drain everything before going on
        wait (pending == 0);
        no_idle = 1'b1;
        repeat (40) random_req();
        no_idle = 1'b0;
      end else begin
        repeat (10) random_req();
      end
    end

    wait (pending == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d refused (empty/full/bad pos)",
             items_sent, results_seen, refused_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
